/* hdl/pned_pkg.sv */
`default_nettype none
package pned_pkg;

    localparam int DIV_BITS = 64;

    localparam logic [63:0] POS_SAT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_SAT = 64'h8000_0000_0000_0000;
    localparam logic [32:0] OFFSET_RESET = 33'd1;

    typedef enum logic [1:0] {
        KIND_COLLISION = 2'd0,
        KIND_FACET     = 2'd1,
        KIND_CENSUS    = 2'd2
    } t_kind;

    // Values that ride along the divider next to the quotient.
    typedef struct packed {
        logic [62:0] coll;
        logic [62:0] cens;
        logic        on_x;
        logic        neg;
        logic        dzero;
        logic        ovf;
    } t_side;

endpackage
`default_nettype wire

/* hdl/pned_div.sv */
`default_nettype none
module pned_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [33:0]   i_rem,
    input  wire logic [63:0]   i_num,
    input  wire logic [33:0]   i_den,
    input  wire pned_pkg::t_side i_side,
    output logic               o_vld,
    output logic [63:0]        o_quo,
    output pned_pkg::t_side    o_side
);
    import pned_pkg::*;

    logic        r_vld  [DIV_BITS];
    logic [33:0] r_rem  [DIV_BITS];
    logic [63:0] r_num  [DIV_BITS];
    logic [63:0] r_quo  [DIV_BITS];
    logic [33:0] r_den  [DIV_BITS];
    t_side       r_side [DIV_BITS];

    logic [33:0] n_rem [DIV_BITS];
    logic [63:0] n_quo [DIV_BITS];

    // One quotient bit per stage: shift in the next dividend bit, then
    // compare and subtract.
    always_comb begin
        logic [34:0] rr;
        logic [33:0] den;
        logic [63:0] quo;
        logic        ge;
        for (int k = 0; k < DIV_BITS; k++) begin
            if (k == 0) begin
                rr  = {i_rem, i_num[63]};
                den = i_den;
                quo = 64'd0;
            end else begin
                rr  = {r_rem[k-1], r_num[k-1][63]};
                den = r_den[k-1];
                quo = r_quo[k-1];
            end
            ge  = (rr >= {1'b0, den});
            n_rem[k] = ge ? 34'(rr - {1'b0, den}) : rr[33:0];
            n_quo[k] = {quo[62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_BITS; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < DIV_BITS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_rem[0];
        r_quo[0]  <= n_quo[0];
        r_num[0]  <= {i_num[62:0], 1'b0};
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int k = 1; k < DIV_BITS; k++) begin
            r_rem[k]  <= n_rem[k];
            r_quo[k]  <= n_quo[k];
            r_num[k]  <= {r_num[k-1][62:0], 1'b0};
            r_den[k]  <= r_den[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_vld  = r_vld[DIV_BITS-1];
    assign o_quo  = r_quo[DIV_BITS-1];
    assign o_side = r_side[DIV_BITS-1];

endmodule
`default_nettype wire

/* hdl/particle_next_event_select_top.sv */
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------------
// item      | in        | start, busy                | i_pos_*, i_dir_*, i_speed, i_edge_*,
//           |           |                            | i_paths_to_collision, i_cell_free_path,
//           |           |                            | i_time_left
// result    | out       | o_valid (one-cycle strobe) | o_next_kind, o_facet_on_x,
//           |           |                            | o_facet_distance
// config    | in        | i_cfg_valid, o_cfg_ready   | i_cfg_data (open bound offset)
//
// One item is taken every cycle; busy never rises.
// A result passes through the five arithmetic stages, then the 64-stage
// one-bit-per-stage divider for the face distance and an output register.
// The synchronous reset clears all valid bits and sets the offset to one.
// The pipeline never stalls, since the receiver takes every result beat.
`default_nettype none
module particle_next_event_select_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_pos_x,
    input  wire logic [63:0] i_pos_y,
    input  wire logic [33:0] i_dir_x,
    input  wire logic [33:0] i_dir_y,
    input  wire logic [62:0] i_speed,
    input  wire logic [63:0] i_edge_x_low,
    input  wire logic [63:0] i_edge_x_high,
    input  wire logic [63:0] i_edge_y_low,
    input  wire logic [63:0] i_edge_y_high,
    input  wire logic [62:0] i_paths_to_collision,
    input  wire logic [62:0] i_cell_free_path,
    input  wire logic [62:0] i_time_left,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [32:0] i_cfg_data,
    output logic             o_valid,
    output logic [1:0]       o_next_kind,
    output logic             o_facet_on_x,
    output logic [63:0]      o_facet_distance
);
    import pned_pkg::*;

    logic [32:0] r_offset;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_offset <= i_cfg_data;
        end
    end

    // Stage A: signed distance to the face ahead along each axis, already
    // oriented so that a positive value lies ahead of the particle.
    logic signed [65:0] n_a_nx, n_a_ny;
    logic [33:0]        n_a_xmag, n_a_ymag;

    always_comb begin
        logic [65:0] px, py, lx, ly, hx, hy, off;
        px  = {{2{i_pos_x[63]}}, i_pos_x};
        py  = {{2{i_pos_y[63]}}, i_pos_y};
        lx  = {{2{i_edge_x_low[63]}}, i_edge_x_low};
        ly  = {{2{i_edge_y_low[63]}}, i_edge_y_low};
        hx  = {{2{i_edge_x_high[63]}}, i_edge_x_high};
        hy  = {{2{i_edge_y_high[63]}}, i_edge_y_high};
        off = {33'd0, r_offset};
        n_a_nx   = i_dir_x[33] ? $signed(px + off - lx) : $signed(hx - px);
        n_a_ny   = i_dir_y[33] ? $signed(py + off - ly) : $signed(hy - py);
        n_a_xmag = i_dir_x[33] ? 34'(-i_dir_x) : i_dir_x;
        n_a_ymag = i_dir_y[33] ? 34'(-i_dir_y) : i_dir_y;
    end

    logic               r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld;
    logic signed [65:0] r_a_nx, r_a_ny, r_b_nx, r_b_ny, r_c_nx, r_c_ny;
    logic [33:0]        r_a_xmag, r_a_ymag, r_b_xmag, r_b_ymag, r_c_xmag, r_c_ymag;
    logic               r_a_spd0, r_b_spd0, r_c_spd0;
    logic [62:0]        r_a_pc, r_a_cfp, r_a_spd, r_a_tl;

    // Stage B: partial products.
    logic [66:0]        r_b_pxl, r_b_pyl;
    logic signed [67:0] r_b_pxh, r_b_pyh;
    logic [63:0]        r_b_c00, r_b_c01, r_b_c10, r_b_c11;
    logic [63:0]        r_b_s00, r_b_s01, r_b_s10, r_b_s11;

    // Stage C: full products.
    logic signed [100:0] r_c_px, r_c_py;
    logic [125:0]        r_c_cp, r_c_sp;

    // Stage D: face choice and saturated event distances.
    logic               r_d_on_x;
    logic signed [65:0] r_d_num;
    logic [33:0]        r_d_den;
    logic [62:0]        r_d_coll, r_d_cens;

    // Stage E: divider setup.
    logic [33:0] r_e_rem, r_e_den;
    logic [63:0] r_e_num;
    t_side       r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [32:0] nxh, nyh;
        logic signed [34:0] xm, ym;
        logic [65:0]        mag;
        logic [33:0]        mhi;
        logic               c_on_x;

        r_a_nx   <= n_a_nx;
        r_a_ny   <= n_a_ny;
        r_a_xmag <= n_a_xmag;
        r_a_ymag <= n_a_ymag;
        r_a_spd0 <= (i_speed == 63'd0);
        r_a_pc   <= i_paths_to_collision;
        r_a_cfp  <= i_cell_free_path;
        r_a_spd  <= i_speed;
        r_a_tl   <= i_time_left;

        nxh = r_a_nx[65:33];
        nyh = r_a_ny[65:33];
        xm  = $signed({1'b0, r_a_xmag});
        ym  = $signed({1'b0, r_a_ymag});
        r_b_nx   <= r_a_nx;
        r_b_ny   <= r_a_ny;
        r_b_xmag <= r_a_xmag;
        r_b_ymag <= r_a_ymag;
        r_b_spd0 <= r_a_spd0;
        r_b_pxl  <= {34'd0, r_a_nx[32:0]} * {33'd0, r_a_ymag};
        r_b_pyl  <= {34'd0, r_a_ny[32:0]} * {33'd0, r_a_xmag};
        r_b_pxh  <= nxh * ym;
        r_b_pyh  <= nyh * xm;
        r_b_c00  <= {32'd0, r_a_pc[31:0]}  * {32'd0, r_a_cfp[31:0]};
        r_b_c01  <= {32'd0, r_a_pc[31:0]}  * {33'd0, r_a_cfp[62:32]};
        r_b_c10  <= {33'd0, r_a_pc[62:32]} * {32'd0, r_a_cfp[31:0]};
        r_b_c11  <= {33'd0, r_a_pc[62:32]} * {33'd0, r_a_cfp[62:32]};
        r_b_s00  <= {32'd0, r_a_spd[31:0]}  * {32'd0, r_a_tl[31:0]};
        r_b_s01  <= {32'd0, r_a_spd[31:0]}  * {33'd0, r_a_tl[62:32]};
        r_b_s10  <= {33'd0, r_a_spd[62:32]} * {32'd0, r_a_tl[31:0]};
        r_b_s11  <= {33'd0, r_a_spd[62:32]} * {33'd0, r_a_tl[62:32]};

        r_c_nx   <= r_b_nx;
        r_c_ny   <= r_b_ny;
        r_c_xmag <= r_b_xmag;
        r_c_ymag <= r_b_ymag;
        r_c_spd0 <= r_b_spd0;
        r_c_px   <= $signed({r_b_pxh, 33'd0}) + $signed({34'd0, r_b_pxl});
        r_c_py   <= $signed({r_b_pyh, 33'd0}) + $signed({34'd0, r_b_pyl});
        r_c_cp   <= {r_b_c11[61:0], 64'd0} + {31'd0, r_b_c10[62:0], 32'd0}
                  + {31'd0, r_b_c01[62:0], 32'd0} + {62'd0, r_b_c00};
        r_c_sp   <= {r_b_s11[61:0], 64'd0} + {31'd0, r_b_s10[62:0], 32'd0}
                  + {31'd0, r_b_s01[62:0], 32'd0} + {62'd0, r_b_s00};

        // Times compare exactly by cross-multiplying; ties go to y.
        if (r_c_spd0 || r_c_xmag == 34'd0) begin
            c_on_x = 1'b0;
        end else if (r_c_ymag == 34'd0) begin
            c_on_x = 1'b1;
        end else begin
            c_on_x = (r_c_px < r_c_py);
        end
        r_d_on_x <= c_on_x;
        r_d_num  <= c_on_x ? r_c_nx : r_c_ny;
        r_d_den  <= c_on_x ? r_c_xmag : r_c_ymag;
        r_d_coll <= (r_c_cp[125:95] != 31'd0) ? POS_SAT[62:0] : r_c_cp[94:32];
        r_d_cens <= (r_c_sp[125:95] != 31'd0) ? POS_SAT[62:0] : r_c_sp[94:32];

        // The dividend is the magnitude shifted up by 32; its top 34 bits
        // seed the remainder, and a seed not below the divisor overflows.
        mag = r_d_num[65] ? 66'(-r_d_num) : r_d_num;
        mhi = mag[65:32];
        r_e_rem        <= mhi;
        r_e_num        <= {mag[31:0], 32'd0};
        r_e_den        <= r_d_den;
        r_e_side.coll  <= r_d_coll;
        r_e_side.cens  <= r_d_cens;
        r_e_side.on_x  <= r_d_on_x;
        r_e_side.neg   <= r_d_num[65];
        r_e_side.dzero <= (r_d_den == 34'd0);
        r_e_side.ovf   <= (mhi >= r_d_den);
    end

    logic        w_div_vld;
    logic [63:0] w_quo;
    t_side       w_side;

    pned_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_e_vld),
        .i_rem   (r_e_rem),
        .i_num   (r_e_num),
        .i_den   (r_e_den),
        .i_side  (r_e_side),
        .o_vld   (w_div_vld),
        .o_quo   (w_quo),
        .o_side  (w_side)
    );

    logic [63:0] n_fd;
    t_kind       n_kind;

    always_comb begin
        if (w_side.dzero) begin
            n_fd = POS_SAT;
        end else if (w_side.ovf) begin
            n_fd = w_side.neg ? NEG_SAT : POS_SAT;
        end else if (w_side.neg) begin
            n_fd = (w_quo > NEG_SAT) ? NEG_SAT : 64'(-w_quo);
        end else begin
            n_fd = w_quo[63] ? POS_SAT : w_quo;
        end

        if (w_side.coll < w_side.cens && $signed({1'b0, w_side.coll}) < $signed(n_fd)) begin
            n_kind = KIND_COLLISION;
        end else if ($signed(n_fd) < $signed({1'b0, w_side.cens})) begin
            n_kind = KIND_FACET;
        end else begin
            n_kind = KIND_CENSUS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_next_kind      <= n_kind;
        o_facet_on_x     <= w_side.on_x;
        o_facet_distance <= n_fd;
    end

endmodule
`default_nettype wire

/* hdl/pned_checker.sv */
`default_nettype none
module pned_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        busy,
    input wire logic        o_cfg_ready,
    input wire logic        o_valid,
    input wire logic [1:0]  o_next_kind,
    input wire logic [63:0] o_facet_distance
);
    import pned_pkg::*;

    // A full pipeline still takes a new item every cycle.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("config port not ready");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_next_kind == KIND_COLLISION || o_next_kind == KIND_FACET
                     || o_next_kind == KIND_CENSUS))
        else $error("undefined event kind");

    // A facet is never chosen at the positive saturation distance.
    a_facet_finite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_next_kind == KIND_FACET) |-> (o_facet_distance != POS_SAT))
        else $error("facet chosen at saturated distance");

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

endmodule

bind particle_next_event_select_top pned_checker u_pned_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .busy             (busy),
    .o_cfg_ready      (o_cfg_ready),
    .o_valid          (o_valid),
    .o_next_kind      (o_next_kind),
    .o_facet_distance (o_facet_distance)
);
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import pned_pkg::*;

    localparam int LATENCY = 70;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] pos_x, pos_y;
        logic [33:0] dir_x, dir_y;
        logic [62:0] speed;
        logic [63:0] edge_x_low, edge_x_high, edge_y_low, edge_y_high;
        logic [62:0] paths, free_path, time_left;
    } particle_t;

    typedef struct packed {
        t_kind       kind;
        logic        on_x;
        logic [63:0] distance;
    } event_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    particle_t drive_item = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [32:0] i_cfg_data = '0;
    logic o_valid;
    logic [1:0] o_next_kind;
    logic o_facet_on_x;
    logic [63:0] o_facet_distance;

    particle_t pending_particles[$];
    event_t expected_events[$];
    logic [32:0] offset_model = OFFSET_RESET;
    int sender_idle_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    particle_next_event_select_top u_top (
        .i_clk, .i_rst_n, .start, .busy,
        .i_pos_x(drive_item.pos_x), .i_pos_y(drive_item.pos_y),
        .i_dir_x(drive_item.dir_x), .i_dir_y(drive_item.dir_y),
        .i_speed(drive_item.speed),
        .i_edge_x_low(drive_item.edge_x_low), .i_edge_x_high(drive_item.edge_x_high),
        .i_edge_y_low(drive_item.edge_y_low), .i_edge_y_high(drive_item.edge_y_high),
        .i_paths_to_collision(drive_item.paths), .i_cell_free_path(drive_item.free_path),
        .i_time_left(drive_item.time_left),
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .o_valid, .o_next_kind, .o_facet_on_x, .o_facet_distance
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic particle_t rand_raw();
        return {rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                rand64(), rand64(), rand64(), rand64()};
    endfunction

    function automatic logic [62:0] fixed_product(logic [62:0] a, logic [62:0] b);
        logic [125:0] p;
        p = a * b;
        if (|p[125:95]) return MAX63;
        return p[94:32];
    endfunction

    function automatic logic [63:0] face_distance(logic signed [67:0] delta, logic dneg,
                                                  logic [33:0] dmag);
        logic [67:0] mag;
        logic [127:0] quo;
        if (dmag == 0) return POS_SAT;
        mag = delta[67] ? -delta : delta;
        quo = {28'd0, mag, 32'd0} / {94'd0, dmag};
        if (delta[67] ^ dneg) begin
            if (quo > {64'd0, NEG_SAT}) return NEG_SAT;
            return -quo[63:0];
        end
        if (quo > {64'd0, POS_SAT}) return POS_SAT;
        return quo[63:0];
    endfunction

    function automatic event_t predict_event(particle_t p, logic [32:0] offset);
        logic xneg, yneg;
        logic [33:0] xmag, ymag;
        logic signed [67:0] delx, dely, nx, ny;
        logic signed [127:0] tx, ty;
        logic [62:0] coll, cens;
        event_t ev;
        xneg = p.dir_x[33];
        yneg = p.dir_y[33];
        xmag = xneg ? ~p.dir_x + 34'd1 : p.dir_x;
        ymag = yneg ? ~p.dir_y + 34'd1 : p.dir_y;
        delx = xneg ? 68'($signed(p.edge_x_low)) - $signed({35'd0, offset})
                      - 68'($signed(p.pos_x))
                    : 68'($signed(p.edge_x_high)) - 68'($signed(p.pos_x));
        dely = yneg ? 68'($signed(p.edge_y_low)) - $signed({35'd0, offset})
                      - 68'($signed(p.pos_y))
                    : 68'($signed(p.edge_y_high)) - 68'($signed(p.pos_y));
        if (p.speed == 0 || xmag == 0) begin
            ev.on_x = 1'b0;
        end else if (ymag == 0) begin
            ev.on_x = 1'b1;
        end else begin
            // Cross-multiplied times, so the comparison stays exact.
            nx = xneg ? -delx : delx;
            ny = yneg ? -dely : dely;
            tx = 128'(nx) * $signed({94'd0, ymag});
            ty = 128'(ny) * $signed({94'd0, xmag});
            ev.on_x = tx < ty;
        end
        ev.distance = ev.on_x ? face_distance(delx, xneg, xmag)
                              : face_distance(dely, yneg, ymag);
        coll = fixed_product(p.paths, p.free_path);
        cens = fixed_product(p.speed, p.time_left);
        if (coll < cens && $signed({1'b0, coll}) < $signed(ev.distance)) begin
            ev.kind = KIND_COLLISION;
        end else if ($signed(ev.distance) < $signed({1'b0, cens})) begin
            ev.kind = KIND_FACET;
        end else begin
            ev.kind = KIND_CENSUS;
        end
        return ev;
    endfunction

    // Driver: one beat per accepted start, refilled from the pending queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) expected_events.push_back(predict_event(drive_item, offset_model));
            if (pending_particles.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                drive_item <= pending_particles.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) offset_model <= i_cfg_data;
        if (i_rst_n && o_valid) begin
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
            end else begin
                event_t ev;
                ev = expected_events.pop_front();
                if (o_next_kind !== ev.kind || o_facet_on_x !== ev.on_x
                        || o_facet_distance !== ev.distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind %0d on_x %0b dist %h, got %0d %0b %h",
                                 ev.kind, ev.on_x, ev.distance,
                                 o_next_kind, o_facet_on_x, o_facet_distance);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("particle_next_event_select_top regression: fail");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_particles.size() > 0 || start || expected_events.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_offset(logic [32:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic particle_t random_particle();
        particle_t p;
        logic [63:0] width;
        p = '0;
        if ($urandom_range(9) < 2) begin
            p = rand_raw();
            return p;
        end
        // A well-formed particle sitting inside its cell.
        p.edge_x_low = {{24{1'b0}}, 8'($urandom), $urandom} - 64'(1 << 30) * 64'(1 << 10);
        width = {$urandom_range(0, 999), $urandom} + 64'd1;
        p.edge_x_high = p.edge_x_low + width;
        p.pos_x = p.edge_x_low + {32'd0, $urandom} * (width >> 32);
        if ($urandom_range(3) == 0) p.pos_x = p.edge_x_low;
        p.edge_y_low = {{24{1'b0}}, 8'($urandom), $urandom} - 64'(1 << 30) * 64'(1 << 10);
        width = {$urandom_range(0, 999), $urandom} + 64'd1;
        p.edge_y_high = p.edge_y_low + width;
        p.pos_y = p.edge_y_low + {32'd0, $urandom} * (width >> 32);
        p.dir_x = $urandom_range(9) == 0 ? 34'd0 : 34'($signed({1'b0, $urandom}))
                  - ($urandom_range(1) ? 34'd0 : 34'h1_0000_0000);
        p.dir_y = $urandom_range(9) == 0 ? 34'd0 : 34'($signed({1'b0, $urandom}))
                  - ($urandom_range(1) ? 34'd0 : 34'h1_0000_0000);
        p.speed = $urandom_range(19) == 0 ? 63'd0 : 63'({$urandom_range(0, 99), $urandom});
        p.paths = 63'({$urandom_range(0, 9), $urandom});
        p.free_path = 63'({$urandom_range(0, 199), $urandom});
        p.time_left = 63'({$urandom_range(0, 19), $urandom});
        return p;
    endfunction

    initial begin
        particle_t p;
        logic [32:0] offsets[4];
        int idle_levels[4];
        offsets = '{33'd0, 33'h1_0000_0000, 33'd1, 33'd0};
        idle_levels = '{0, 48, 9, 0};
        offsets[3] = {1'b0, $urandom};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners under the reset offset.
        p = random_particle();
        p.pos_x = 64'h8000_0000_0000_0000;
        p.pos_y = 64'h7FFF_FFFF_FFFF_FFFF;
        p.edge_x_low = 64'h8000_0000_0000_0000;
        p.edge_x_high = 64'h7FFF_FFFF_FFFF_FFFF;
        p.edge_y_low = 64'h8000_0000_0000_0000;
        p.edge_y_high = 64'h7FFF_FFFF_FFFF_FFFF;
        for (int k = 0; k < 9; k++) begin
            p.dir_x = k % 3 == 0 ? 34'd0 : k % 3 == 1 ? 34'h1_0000_0000 : 34'h3_0000_0000;
            p.dir_y = k / 3 == 0 ? 34'd0 : k / 3 == 1 ? 34'h0_0000_0001 : 34'h2_0000_0000;
            p.speed = k == 4 ? 63'd0 : MAX63;
            p.paths = k[0] ? MAX63 : 63'd0;
            p.free_path = MAX63;
            p.time_left = k[1] ? MAX63 : 63'd1;
            pending_particles.push_back(p);
        end
        for (int k = 0; k < 8; k++) begin
            p = random_particle();
            // Equal distances on both axes when both directions share a sign, so the y face must win the tie.
            p.pos_x = '0; p.pos_y = '0;
            p.edge_x_high = 64'h1_0000_0000; p.edge_y_high = 64'h1_0000_0000;
            p.edge_x_low = -64'h1_0000_0000; p.edge_y_low = -64'h1_0000_0000;
            p.dir_x = k[0] ? 34'h0_8000_0000 : -34'h0_8000_0000;
            p.dir_y = k[1] ? 34'h0_8000_0000 : -34'h0_8000_0000;
            p.speed = k[2] ? 63'h1_0000_0000 : 63'd1;
            pending_particles.push_back(p);
        end
        for (int k = 0; k < 6; k++) begin
            p = rand_raw();
            p.dir_x = k[0] ? 34'h3_FFFF_FFFF : 34'h1_FFFF_FFFF;
            p.dir_y = k[1] ? 34'h2_0000_0001 : 34'h0_0000_0000;
            pending_particles.push_back(p);
        end
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_offset(offsets[ph]);
            sender_idle_pct = idle_levels[ph];
            repeat (2) @(posedge i_clk);
            for (int n = 0; n < 335; n++) pending_particles.push_back(random_particle());
            drain();
        end

        if (mismatches == 0) begin
            $display("particle_next_event_select_top regression: pass");
        end else begin
            $display("particle_next_event_select_top regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
hdl/pned_pkg.sv
hdl/pned_div.sv
hdl/particle_next_event_select_top.sv
hdl/pned_checker.sv
test/testbench.sv
